>>> rtl/gregorian_day_number_convert_macros.svh
// assertion helpers for the converter, used inside the top level scope
`ifndef GREGORIAN_DAY_NUMBER_CONVERT_MACROS_SVH
`define GREGORIAN_DAY_NUMBER_CONVERT_MACROS_SVH

// same-cycle implication
`define GDNC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDNC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gdnc_pkg.sv
`default_nettype none

package gdnc_pkg;

	localparam int NSTAGES = 9;

	typedef logic [NSTAGES:1] stage_en_t;

	typedef enum logic {
		CMD_TO_SERIAL = 1'b0,
		CMD_TO_DATE   = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic nz;
	} tag_t;

	localparam logic [14:0] DAY_OFFSET  = 15'd32045;
	localparam logic [7:0]  DAYS_5_MON  = 8'd153;
	localparam logic [10:0] DAYS_4_YR   = 11'd1461;
	localparam logic [17:0] DAYS_400_YR = 18'd146097;
	localparam logic [6:0]  YEAR_CENT   = 7'd100;

	localparam logic signed [15:0] YEAR_BIAS    = 16'sd4800;
	localparam logic signed [15:0] YEAR_BIAS_BC = 16'sd4801;
	localparam logic signed [15:0] YEAR_MIN     = -16'sd4714;
	localparam logic [3:0]         FIRST_MONTH  = 4'd11;
	localparam logic [4:0]         FIRST_DAY    = 5'd25;

	// reciprocals for the constant dividers, quotient = (x * r) >> shift, then one fix-up
	localparam logic [8:0] RECIP_400YR = 9'd459;
	localparam int         SHIFT_400YR = 26;
	localparam logic [7:0] RECIP_4YR   = 8'd179;
	localparam int         SHIFT_4YR   = 18;
	localparam logic [3:0] RECIP_5MON  = 4'd13;
	localparam int         SHIFT_5MON  = 11;
	localparam logic [8:0] RECIP_CENT  = 9'd327;
	localparam int         SHIFT_CENT  = 15;
	// exact for values below 1024, no fix-up needed
	localparam logic [7:0] RECIP_DIV5  = 8'd205;
	localparam int         SHIFT_DIV5  = 10;

	// day count from 1 March to the first of the month
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:  r = 9'd306;
			4'd2:  r = 9'd337;
			4'd3:  r = 9'd0;
			4'd4:  r = 9'd31;
			4'd5:  r = 9'd61;
			4'd6:  r = 9'd92;
			4'd7:  r = 9'd122;
			4'd8:  r = 9'd153;
			4'd9:  r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			4'd12: r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:  r = leap ? 5'd29 : 5'd28;
			4'd4:  r = 5'd30;
			4'd6:  r = 5'd30;
			4'd9:  r = 5'd30;
			4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gdnc_date2ser.sv
`default_nettype none

module gdnc_date2ser import gdnc_pkg::*; (
	input  wire logic               clk,
	input  wire stage_en_t          en,
	input  wire logic signed [14:0] date_year,
	input  wire logic [3:0]         date_month,
	input  wire logic [4:0]         date_day,
	output logic [22:0]             serial,
	output logic                    ok
);

	// stage 1: year bias, march-based year, range checks
	logic signed [15:0] yr_ext;
	logic [15:0]        yy0_w;
	logic               feb_w;
	logic               rng_ok_w;

	assign yr_ext = 16'(date_year);
	assign yy0_w  = 16'(yr_ext + ((yr_ext < 16'sd0) ? YEAR_BIAS_BC : YEAR_BIAS));
	assign feb_w  = date_month <= 4'd2;

	always_comb begin
		rng_ok_w = (date_year != 15'sd0) && (yr_ext >= YEAR_MIN) &&
			(date_month >= 4'd1) && (date_month <= 4'd12) && (date_day != 5'd0);
		// the count starts on 25 november of its first year
		if (yr_ext == YEAR_MIN &&
			(date_month < FIRST_MONTH || (date_month == FIRST_MONTH && date_day < FIRST_DAY))) begin
			rng_ok_w = 1'b0;
		end
	end

	logic [14:0] yy_s1, yy0_s1;
	logic [8:0]  moff_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic        ok_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			yy_s1    <= yy0_w[14:0] - 15'(feb_w);
			yy0_s1   <= yy0_w[14:0];
			moff_s1  <= month_offset(date_month);
			month_s1 <= date_month;
			day_s1   <= date_day;
			ok_s1    <= rng_ok_w;
		end
	end

	// stage 2: reciprocal estimates of the century
	logic [23:0] qp_w, qp0_w;
	assign qp_w  = 24'(yy_s1) * 24'(RECIP_CENT);
	assign qp0_w = 24'(yy0_s1) * 24'(RECIP_CENT);

	logic [14:0] yy_s2, yy0_s2;
	logic [7:0]  qe_s2, qe0_s2;
	logic [8:0]  moff_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic        ok_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			yy_s2    <= yy_s1;
			yy0_s2   <= yy0_s1;
			qe_s2    <= qp_w[SHIFT_CENT +: 8];
			qe0_s2   <= qp0_w[SHIFT_CENT +: 8];
			moff_s2  <= moff_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			ok_s2    <= ok_s1;
		end
	end

	// stage 3: fix up the estimates, leap year from the unshifted year
	logic [15:0] rem_w, rem0_w;
	logic [7:0]  q_w, q0_w;
	logic [6:0]  r_w, r0_w;
	logic        leap_w;

	assign rem_w  = 16'(yy_s2) - 16'(qe_s2) * 16'(YEAR_CENT);
	assign rem0_w = 16'(yy0_s2) - 16'(qe0_s2) * 16'(YEAR_CENT);

	always_comb begin
		if (rem_w >= 16'(YEAR_CENT)) begin
			q_w = qe_s2 + 8'd1;
			r_w = 7'(rem_w - 16'(YEAR_CENT));
		end else begin
			q_w = qe_s2;
			r_w = rem_w[6:0];
		end
		if (rem0_w >= 16'(YEAR_CENT)) begin
			q0_w = qe0_s2 + 8'd1;
			r0_w = 7'(rem0_w - 16'(YEAR_CENT));
		end else begin
			q0_w = qe0_s2;
			r0_w = rem0_w[6:0];
		end
		// bias of 4800 keeps the 400-year cycle aligned
		leap_w = (yy0_s2[1:0] == 2'd0) && ((r0_w != 7'd0) || (q0_w[1:0] == 2'd0));
	end

	logic [7:0] q_s3;
	logic [6:0] r_s3;
	logic       leap_s3;
	logic [8:0] moff_s3;
	logic [3:0] month_s3;
	logic [4:0] day_s3;
	logic       ok_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q_s3     <= q_w;
			r_s3     <= r_w;
			leap_s3  <= leap_w;
			moff_s3  <= moff_s2;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
			ok_s3    <= ok_s2;
		end
	end

	// stage 4: day counts of whole centuries and years, month length check
	logic [25:0] cdays_w;
	logic [17:0] ydays_w;
	assign cdays_w = 26'(q_s3) * 26'(DAYS_400_YR);
	assign ydays_w = 18'(r_s3) * 18'(DAYS_4_YR);

	logic [22:0] cdays_s4;
	logic [15:0] ydays_s4;
	logic [8:0]  moff_s4;
	logic [4:0]  day_s4;
	logic        ok_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			cdays_s4 <= cdays_w[24:2];
			ydays_s4 <= ydays_w[17:2];
			moff_s4  <= moff_s3;
			day_s4   <= day_s3;
			ok_s4    <= ok_s3 && (day_s3 <= month_days(month_s3, leap_s3));
		end
	end

	// stage 5: final sum
	logic [23:0] sum_w;
	assign sum_w = 24'(cdays_s4) + 24'(ydays_s4) + 24'(moff_s4) + 24'(day_s4)
		- 24'(DAY_OFFSET);

	logic [22:0] ser_s5, ser_s6, ser_s7, ser_s8, ser_s9;
	logic        ok_s5, ok_s6, ok_s7, ok_s8, ok_s9;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ser_s5 <= sum_w[22:0];
			ok_s5  <= ok_s4;
		end
		if (en[6]) begin
			ser_s6 <= ser_s5;
			ok_s6  <= ok_s5;
		end
		if (en[7]) begin
			ser_s7 <= ser_s6;
			ok_s7  <= ok_s6;
		end
		if (en[8]) begin
			ser_s8 <= ser_s7;
			ok_s8  <= ok_s7;
		end
		if (en[9]) begin
			ser_s9 <= ser_s8;
			ok_s9  <= ok_s8;
		end
	end

	assign serial = ser_s9;
	assign ok     = ok_s9;

endmodule

`default_nettype wire

>>> rtl/gdnc_ser2date.sv
`default_nettype none

module gdnc_ser2date import gdnc_pkg::*; (
	input  wire logic        clk,
	input  wire stage_en_t   en,
	input  wire logic [22:0] serial_in,
	output logic signed [15:0] year,
	output logic [3:0]       month,
	output logic [4:0]       day
);

	// stage 1: t = 4 * (serial + offset) - 1
	logic [25:0] t_w;
	assign t_w = ((26'(serial_in) + 26'(DAY_OFFSET)) << 2) - 26'd1;

	logic [25:0] t_s1;
	always_ff @(posedge clk) begin
		if (en[1]) t_s1 <= t_w;
	end

	// stage 2: estimate of the 400-year cycle count
	logic [34:0] cp_w;
	assign cp_w = 35'(t_s1) * 35'(RECIP_400YR);

	logic [25:0] t_s2;
	logic [7:0]  ce_s2;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s2  <= t_s1;
			ce_s2 <= cp_w[SHIFT_400YR +: 8];
		end
	end

	// stage 3: fix up, then round the remainder down to a multiple of four plus 3
	logic [25:0] crem_w;
	logic [7:0]  cent_w;
	logic [17:0] t3_w;

	assign crem_w = t_s2 - 26'(ce_s2) * 26'(DAYS_400_YR);

	always_comb begin
		if (crem_w >= 26'(DAYS_400_YR)) begin
			cent_w = ce_s2 + 8'd1;
			t3_w   = 18'(crem_w - 26'(DAYS_400_YR));
		end else begin
			cent_w = ce_s2;
			t3_w   = crem_w[17:0];
		end
		t3_w[1:0] = 2'b11;
	end

	logic [7:0]  cent_s3;
	logic [17:0] t3_s3;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			cent_s3 <= cent_w;
			t3_s3   <= t3_w;
		end
	end

	// stage 4: estimate of the year inside the century
	logic [25:0] yp_w;
	assign yp_w = 26'(t3_s3) * 26'(RECIP_4YR);

	logic [7:0]  cent_s4;
	logic [17:0] t3_s4;
	logic [6:0]  ye_s4;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			cent_s4 <= cent_s3;
			t3_s4   <= t3_s3;
			ye_s4   <= yp_w[SHIFT_4YR +: 7];
		end
	end

	// stage 5: fix up the year estimate
	logic [17:0] yrem_w;
	logic [6:0]  yq_w;
	logic [10:0] yrem1_w;

	assign yrem_w = t3_s4 - 18'(ye_s4) * 18'(DAYS_4_YR);

	always_comb begin
		if (yrem_w >= 18'(DAYS_4_YR)) begin
			yq_w    = ye_s4 + 7'd1;
			yrem1_w = 11'(yrem_w - 18'(DAYS_4_YR));
		end else begin
			yq_w    = ye_s4;
			yrem1_w = yrem_w[10:0];
		end
	end

	logic [7:0]  cent_s5;
	logic [6:0]  yq_s5;
	logic [10:0] yrem_s5;
	always_ff @(posedge clk) begin
		if (en[5]) begin
			cent_s5 <= cent_s4;
			yq_s5   <= yq_w;
			yrem_s5 <= yrem1_w;
		end
	end

	// stage 6: march-based year, tt = 5 * day_of_year - 3
	logic [14:0] yr_w;
	logic [10:0] tt_w;
	assign yr_w = 15'(cent_s5) * 15'(YEAR_CENT) + 15'(yq_s5);
	assign tt_w = 11'(yrem_s5[10:2]) * 11'd5 + 11'd2;

	logic [14:0] yr_s6;
	logic [10:0] tt_s6;
	always_ff @(posedge clk) begin
		if (en[6]) begin
			yr_s6 <= yr_w;
			tt_s6 <= tt_w;
		end
	end

	// stage 7: month estimate
	logic [14:0] mp_w;
	assign mp_w = 15'(tt_s6) * 15'(RECIP_5MON);

	logic [14:0] yr_s7;
	logic [10:0] tt_s7;
	logic [3:0]  me_s7;
	always_ff @(posedge clk) begin
		if (en[7]) begin
			yr_s7 <= yr_s6;
			tt_s7 <= tt_s6;
			me_s7 <= mp_w[SHIFT_5MON +: 4];
		end
	end

	// stage 8: fix up the month estimate
	logic [10:0] mrem_w;
	logic [3:0]  mon_w;
	logic [7:0]  mrem1_w;

	assign mrem_w = tt_s7 - 11'(me_s7) * 11'(DAYS_5_MON);

	always_comb begin
		if (mrem_w >= 11'(DAYS_5_MON)) begin
			mon_w   = me_s7 + 4'd1;
			mrem1_w = 8'(mrem_w - 11'(DAYS_5_MON));
		end else begin
			mon_w   = me_s7;
			mrem1_w = mrem_w[7:0];
		end
	end

	logic [14:0] yr_s8;
	logic [3:0]  mon_s8;
	logic [7:0]  mrem_s8;
	always_ff @(posedge clk) begin
		if (en[8]) begin
			yr_s8   <= yr_s7;
			mon_s8  <= mon_w;
			mrem_s8 <= mrem1_w;
		end
	end

	// stage 9: day, back to january-based month, drop year zero
	logic [15:0]        dp_w;
	logic               late_w;
	logic signed [15:0] ya_w;
	logic signed [15:0] yb_w;

	assign dp_w   = 16'(mrem_s8) * 16'(RECIP_DIV5);
	assign late_w = mon_s8 >= 4'd10;
	assign ya_w   = $signed(16'(yr_s8) + 16'(late_w)) - YEAR_BIAS;
	assign yb_w   = (ya_w <= 16'sd0) ? ya_w - 16'sd1 : ya_w;

	logic signed [15:0] year_s9;
	logic [3:0]         month_s9;
	logic [4:0]         day_s9;
	always_ff @(posedge clk) begin
		if (en[9]) begin
			year_s9  <= yb_w;
			month_s9 <= late_w ? mon_s8 - 4'd9 : mon_s8 + 4'd3;
			day_s9   <= dp_w[SHIFT_DIV5 +: 5] + 5'd1;
		end
	end

	assign year  = year_s9;
	assign month = month_s9;
	assign day   = day_s9;

endmodule

`default_nettype wire

>>> rtl/gregorian_day_number_convert.sv
// Converts between a proleptic Gregorian date and a serial day number (serial 1 is
// 25 Nov 4714 BC, no year 0, 1 BC is year -1). Each request gives exactly one result.
// Request tuser selects the direction: 0 turns year, month and day into a serial,
// rejecting out-of-range years, months, days and dates that do not exist; 1 turns a
// serial into a date, serial 0 giving all zeros. Both directions run through one
// nine-stage pipeline of reciprocal-multiply constant dividers; a new request is taken
// every cycle unless a stalled output has backed up every stage. Each stage advances on
// its own ready, so empty stages close up while the output is stalled.
`default_nettype none

`include "gregorian_day_number_convert_macros.svh"

module gregorian_day_number_convert import gdnc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // date_year[14:0], date_month[18:15],
	                                   // date_day[23:19], serial_in[46:24], pad
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // serial_out[22:0], year_out[38:23],
	                                   // month_out[42:39], day_out[47:43]
	output logic             m_tuser   // valid_res
);

	logic signed [14:0] date_year;
	logic [3:0]         date_month;
	logic [4:0]         date_day;
	logic [22:0]        serial_in;
	cmd_t               cmd;

	assign date_year  = s_tdata[14:0];
	assign date_month = s_tdata[18:15];
	assign date_day   = s_tdata[23:19];
	assign serial_in  = s_tdata[46:24];
	assign cmd        = cmd_t'(s_tuser);

	// per-stage valid and ready
	logic [NSTAGES:1] vld_q;
	stage_en_t        rdy;

	always_comb begin
		rdy[NSTAGES] = !vld_q[NSTAGES] || m_tready;
		for (int k = NSTAGES - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTAGES; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// direction and nonzero serial follow each request
	tag_t tag_s [1:NSTAGES];

	always_ff @(posedge clk) begin
		if (rdy[1]) tag_s[1] <= '{cmd: cmd, nz: serial_in != 23'd0};
		for (int k = 2; k <= NSTAGES; k++) begin
			if (rdy[k]) tag_s[k] <= tag_s[k - 1];
		end
	end

	logic [22:0]        d2s_serial;
	logic               d2s_ok;
	logic signed [15:0] s2d_year;
	logic [3:0]         s2d_month;
	logic [4:0]         s2d_day;

	gdnc_date2ser u_date2ser (
		.clk        (clk),
		.en         (rdy),
		.date_year  (date_year),
		.date_month (date_month),
		.date_day   (date_day),
		.serial     (d2s_serial),
		.ok         (d2s_ok)
	);

	gdnc_ser2date u_ser2date (
		.clk       (clk),
		.en        (rdy),
		.serial_in (serial_in),
		.year      (s2d_year),
		.month     (s2d_month),
		.day       (s2d_day)
	);

	logic               to_date;
	logic               date_ok;
	logic               serial_ok;
	logic [22:0]        serial_out;
	logic signed [15:0] year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;

	assign to_date    = tag_s[NSTAGES].cmd == CMD_TO_DATE;
	assign date_ok    = to_date && tag_s[NSTAGES].nz;
	assign serial_ok  = !to_date && d2s_ok;
	assign serial_out = serial_ok ? d2s_serial : 23'd0;
	assign year_out   = date_ok ? s2d_year : 16'sd0;
	assign month_out  = date_ok ? s2d_month : 4'd0;
	assign day_out    = date_ok ? s2d_day : 5'd0;

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NSTAGES];
	assign m_tdata  = {day_out, month_out, year_out, serial_out};
	assign m_tuser  = date_ok || serial_ok;

	`GDNC_ASSERT_IMP(a_reject_zero, m_tvalid && !m_tuser, m_tdata == 48'd0, "rejected request carries data")
	`GDNC_ASSERT_IMP(a_one_direction, m_tvalid && month_out != 4'd0, serial_out == 23'd0, "date and serial both set")
	`GDNC_ASSERT_IMP(a_date_range, m_tvalid && m_tuser && serial_out == 23'd0, month_out >= 4'd1 && month_out <= 4'd12 && day_out != 5'd0, "date result out of range")
	`GDNC_ASSERT_IMP(a_ready_drained, !m_tvalid, s_tready, "pipeline stalled with empty output")
	`GDNC_ASSERT_NXT(a_stall_keeps, vld_q[NSTAGES] && !m_tready && vld_q[NSTAGES - 1], vld_q[NSTAGES] && vld_q[NSTAGES - 1], "stalled request dropped")

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
	import gdnc_pkg::*;

	localparam int ITEMS_PER_PHASE = 534;
	localparam int QUIET_LIMIT     = 1000;
	localparam int TAIL_CYCLES     = 20;

	// calendar arithmetic constants
	localparam longint EPOCH_SHIFT   = 32045;
	localparam longint FIVE_MONTHS   = 153;
	localparam longint FOUR_YEARS    = 1461;
	localparam longint FOUR_CENTS    = 146097;
	localparam longint AD_YEAR_BIAS  = 4800;
	localparam longint BC_YEAR_BIAS  = 4801;
	localparam longint EARLIEST_YEAR = -4714;
	localparam longint LATEST_YEAR   = 16383;
	localparam int     SERIAL_MAX    = 8388607;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [14:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [22:0]        serial;
	} conv_req_t;

	typedef struct packed {
		logic [22:0]        serial;
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic               valid;
	} conv_res_t;

	typedef struct packed {
		conv_req_t req;
		logic      fixed;
		conv_res_t res;
	} table_row_t;

	typedef struct packed {
		logic      fixed;
		conv_res_t res;
	} typed_answer_t;

	localparam conv_res_t ALL_ZERO = '0;
	localparam int NUM_ROWS = 23;

	// fixed rows carry a typed answer, the rest go through the predictor
	localparam table_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{'{CMD_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd1}, 1'b1,
			'{23'd0, -16'sd4714, 4'd11, 5'd25, 1'b1}},
		'{'{CMD_TO_SERIAL, -15'sd4714, 4'd11, 5'd25, 23'd0}, 1'b1,
			'{23'd1, 16'sd0, 4'd0, 5'd0, 1'b1}},
		'{'{CMD_TO_SERIAL, -15'sd4714, 4'd11, 5'd24, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd0, 4'd6, 5'd15, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, -15'sd4715, 4'd12, 5'd31, 23'd0}, 1'b1, ALL_ZERO},
		// most negative year field
		'{'{CMD_TO_SERIAL, 15'h4000, 4'd1, 5'd1, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd0, 5'd1, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd13, 5'd1, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd15, 5'd31, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd1, 5'd0, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2001, 4'd2, 5'd30, 23'd0}, 1'b1, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd16383, 4'd12, 5'd31, 23'h7fffff}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd16383, 4'd1, 5'd1, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd2, 5'd29, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd1900, 4'd2, 5'd29, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, -15'sd1, 4'd2, 5'd29, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, -15'sd1, 4'd12, 5'd31, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd1, 4'd1, 5'd1, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_SERIAL, 15'sd2000, 4'd4, 5'd31, 23'd0}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'h7fffff}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_DATE, -15'sd1, 4'd15, 5'd31, 23'd2451545}, 1'b0, ALL_ZERO},
		'{'{CMD_TO_DATE, 15'sd16383, 4'd15, 5'd31, 23'h555555}, 1'b0, ALL_ZERO}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	int source_idle_pct = 0;
	int sink_idle_pct   = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;

	typed_answer_t typed_answers [$];
	conv_res_t     expected_conversions [$];

	gregorian_day_number_convert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void serial_to_civil(input longint sdn, output longint y,
			output longint m, output longint d);
		longint t, cent, doy;
		if (sdn <= 0) begin
			y = 0;
			m = 0;
			d = 0;
			return;
		end
		t = (sdn + EPOCH_SHIFT) * 4 - 1;
		cent = t / FOUR_CENTS;
		t = ((t % FOUR_CENTS) / 4) * 4 + 3;
		y = cent * 100 + t / FOUR_YEARS;
		doy = (t % FOUR_YEARS) / 4 + 1;
		t = doy * 5 - 3;
		m = t / FIVE_MONTHS;
		d = (t % FIVE_MONTHS) / 5 + 1;
		// months are counted from march, so jan and feb belong to the next year
		if (m < 10) begin
			m = m + 3;
		end else begin
			y = y + 1;
			m = m - 9;
		end
		y = y - AD_YEAR_BIAS;
		if (y <= 0) begin
			y = y - 1;
		end
	endfunction

	function automatic longint civil_to_serial(input longint y, input longint m, input longint d);
		longint yy, mm;
		if (y == 0 || y < EARLIEST_YEAR || y > LATEST_YEAR || m < 1 || m > 12 || d < 1 || d > 31)
			return 0;
		if (y == EARLIEST_YEAR && (m < 11 || (m == 11 && d < 25)))
			return 0;
		yy = (y < 0) ? y + BC_YEAR_BIAS : y + AD_YEAR_BIAS;
		if (m > 2) begin
			mm = m - 3;
		end else begin
			mm = m + 9;
			yy = yy - 1;
		end
		return ((yy / 100) * FOUR_CENTS) / 4 + ((yy % 100) * FOUR_YEARS) / 4
			+ (mm * FIVE_MONTHS + 2) / 5 + d - EPOCH_SHIFT;
	endfunction

	function automatic conv_res_t convert_request(input conv_req_t r);
		longint y, m, d, s, ry, rm, rd;
		conv_res_t res;
		y = longint'($signed(r.year));
		m = longint'(r.month);
		d = longint'(r.day);
		res = '0;
		if (r.cmd == CMD_TO_SERIAL) begin
			s = civil_to_serial(y, m, d);
			serial_to_civil(s, ry, rm, rd);
			// dates like 30 february do not come back the same
			if (s > 0 && ry == y && rm == m && rd == d) begin
				res.serial = s[22:0];
				res.valid = 1'b1;
			end
		end else begin
			s = longint'(r.serial);
			serial_to_civil(s, ry, rm, rd);
			if (s > 0) begin
				res.year = ry[15:0];
				res.month = rm[3:0];
				res.day = rd[4:0];
				res.valid = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic conv_req_t random_request();
		conv_req_t r;
		int y;
		int top;
		r.cmd = ($urandom_range(99) < 55) ? CMD_TO_SERIAL : CMD_TO_DATE;
		r.year = 15'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		r.serial = 23'($urandom);
		if (r.cmd == CMD_TO_SERIAL) begin
			// mostly well formed dates, the rest stays raw noise
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(9))
					0: begin
						y = int'($urandom_range(9)) - 5;
						if (y >= 0) y++;
					end
					1: y = -4714 + int'($urandom_range(3));
					2: y = 16383 - int'($urandom_range(3));
					default: begin
						y = int'($urandom_range(21096)) - 4714;
						if (y >= 0) y++;
					end
				endcase
				r.year = 15'(y);
				r.month = 4'($urandom_range(1, 12));
				case (r.month)
					4'd2: top = 29;
					4'd4, 4'd6, 4'd9, 4'd11: top = 30;
					default: top = 31;
				endcase
				r.day = 5'($urandom_range(1, top));
			end
		end else begin
			case ($urandom_range(9))
				0: r.serial = 23'($urandom_range(3));
				1: r.serial = 23'($urandom_range(1, 3000));
				2: r.serial = 23'(SERIAL_MAX - int'($urandom_range(3)));
				default: r.serial = 23'($urandom_range(1, SERIAL_MAX));
			endcase
		end
		return r;
	endfunction

	task automatic offer_request(input conv_req_t r, input logic fixed, input conv_res_t res);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		typed_answers.push_back('{fixed, res});
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {1'b0, r.serial, r.day, r.month, r.year};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (typed_answers.size() != 0 || expected_conversions.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : scoreboard
		conv_req_t     seen;
		typed_answer_t note;
		conv_res_t     want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.cmd = cmd_t'(s_tuser);
				seen.year = s_tdata[14:0];
				seen.month = s_tdata[18:15];
				seen.day = s_tdata[23:19];
				seen.serial = s_tdata[46:24];
				note = typed_answers.pop_front();
				expected_conversions.push_back(note.fixed ? note.res : convert_request(seen));
			end
			if (m_tvalid && m_tready) begin
				if (expected_conversions.size() == 0) begin
					$display("%0t: unexpected result, tdata %h tuser %b", $time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_conversions.pop_front();
					check_field("serial_out", longint'(want.serial), longint'(m_tdata[22:0]));
					check_field("year_out", longint'(want.year), longint'($signed(m_tdata[38:23])));
					check_field("month_out", longint'(want.month), longint'(m_tdata[42:39]));
					check_field("day_out", longint'(want.day), longint'(m_tdata[47:43]));
					check_field("valid_res", longint'(want.valid), longint'(m_tuser));
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);
		// hold off until the pipeline is empty
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					source_idle_pct = 7;
					sink_idle_pct = 74;
				end
				1: begin
					source_idle_pct = 74;
					sink_idle_pct = 7;
				end
				default: begin
					source_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer_request(random_request(), 1'b0, ALL_ZERO);
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
